// ----- rtl/fga_pkg.sv -----
// ----------------------------------------------------------------------------
// fga_pkg
// Shared constants, command struct and helpers of the flux grid accumulator.
// ----------------------------------------------------------------------------
package fga_pkg;

    localparam int MAX_RES_DEF = 128;

    // luminance weights, Q0.16, they sum to 1.0
    localparam logic [15:0] W_R = 16'd13933;
    localparam logic [15:0] W_G = 16'd46871;
    localparam logic [15:0] W_B = 16'd4732;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_Z     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_RES  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_AREA  = 3'd5;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 320;
    localparam int SUM_W      = 46;
    localparam int WT_W       = 62;

    // output tdata field offsets
    localparam int O_IRR_R = 0;
    localparam int O_IRR_G = 32;
    localparam int O_IRR_B = 64;
    localparam int O_SUM_R = 96;
    localparam int O_SUM_G = 142;
    localparam int O_SUM_B = 188;
    localparam int O_PEAK  = 234;
    localparam int O_NZ    = 266;
    localparam int O_MEAN  = 281;
    localparam int O_END   = 313;

    typedef struct packed {
        logic capture;
        logic map_en;
        logic addr_en;
        logic rd_en;
        logic add_en;
        logic lum1_en;
        logic lum2_en;
        logic div_start;
        logic qrnd_en;
        logic scale_en;
        logic out_load;
        logic clr_we;
    } fga_cmd_t;

    // round a Q16.16-scaled product back to Q8.8 and saturate to 32 bits
    function automatic logic [31:0] sat_scale(input logic [63:0] p);
        logic [64:0] s;
        s = {1'b0, p} + 65'd32768;
        return (|s[64:48]) ? 32'hFFFF_FFFF : s[47:16];
    endfunction

endpackage

// ----- rtl/fga_div.sv -----
// ----------------------------------------------------------------------------
// fga_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fga_div import fga_pkg::*; #(
    parameter int DVD_W = WT_W,
    parameter int DVS_W = 15
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quot
);
    localparam int CW = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quot_reg, quot_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   shifted;
    logic             qbit;

    always_comb begin
        shifted   = {rem_reg, quot_reg[DVD_W-1]};
        qbit      = (shifted >= {1'b0, dvs_reg});
        rem_next  = qbit ? DVS_W'(shifted - {1'b0, dvs_reg}) : shifted[DVS_W-1:0];
        quot_next = {quot_reg[DVD_W-2:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            quot_reg <= dividend;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- rtl/fga_ctrl.sv -----
// ----------------------------------------------------------------------------
// fga_ctrl
// Sequencer: memory clear sweep after reset, then one transaction at a time.
// ----------------------------------------------------------------------------
module fga_ctrl import fga_pkg::*; #(
    parameter int MAX_RES = MAX_RES_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  logic div_done,
    output fga_cmd_t cmd,
    output logic [((MAX_RES*MAX_RES > 1) ? $clog2(MAX_RES*MAX_RES) : 1)-1:0] clr_addr
);
    localparam int CELLS = MAX_RES * MAX_RES;
    localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0_0000_0000_0001,
        S_IDLE  = 13'b0_0000_0000_0010,
        S_MAP   = 13'b0_0000_0000_0100,
        S_ADDR  = 13'b0_0000_0000_1000,
        S_READ  = 13'b0_0000_0001_0000,
        S_ADD   = 13'b0_0000_0010_0000,
        S_LUM1  = 13'b0_0000_0100_0000,
        S_LUM2  = 13'b0_0000_1000_0000,
        S_DIVS  = 13'b0_0001_0000_0000,
        S_DIV   = 13'b0_0010_0000_0000,
        S_QRND  = 13'b0_0100_0000_0000,
        S_SCALE = 13'b0_1000_0000_0000,
        S_OUT   = 13'b1_0000_0000_0000
    } fga_state_t;

    fga_state_t       state_reg, state_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic             mval_reg, mval_next;
    logic             out_free;

    assign out_free = !mval_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_we = 1'b1;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(CELLS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_MAP;
                end
            end
            S_MAP: begin
                cmd.map_en = 1'b1;
                state_next = S_ADDR;
            end
            S_ADDR: begin
                cmd.addr_en = 1'b1;
                state_next  = S_READ;
            end
            S_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = S_ADD;
            end
            S_ADD: begin
                cmd.add_en = 1'b1;
                state_next = S_LUM1;
            end
            S_LUM1: begin
                cmd.lum1_en = 1'b1;
                state_next  = S_LUM2;
            end
            S_LUM2: begin
                cmd.lum2_en = 1'b1;
                state_next  = S_DIVS;
            end
            S_DIVS: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_QRND;
                end
            end
            S_QRND: begin
                cmd.qrnd_en = 1'b1;
                state_next  = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale_en = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        mval_next = mval_reg;
        if (cmd.out_load) begin
            mval_next = 1'b1;
        end else if (m_ready) begin
            mval_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            mval_reg  <= mval_next;
        end
    end

    assign m_valid  = mval_reg;
    assign clr_addr = clr_reg;

endmodule

// ----- rtl/fga_datapath.sv -----
// ----------------------------------------------------------------------------
// fga_datapath
// Config registers, cell binning, cell store read-modify-write, totals,
// peak, nonzero count, mean divider and output register.
// ----------------------------------------------------------------------------
module fga_datapath import fga_pkg::*; #(
    parameter int MAX_RES = MAX_RES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fga_cmd_t              cmd,
    input  logic [((MAX_RES*MAX_RES > 1) ? $clog2(MAX_RES*MAX_RES) : 1)-1:0] clr_addr,
    output logic                  div_done,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser
);
    localparam int CELLS = MAX_RES * MAX_RES;
    localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CRD_W = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
    localparam int RES_W = $clog2(MAX_RES + 1);
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // configuration
    logic [31:0] org_x_reg, org_z_reg, cpu_x_reg, cpu_z_reg, inv_reg;
    logic [7:0]  gres_reg;
    logic [RES_W-1:0] res_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_x_reg <= '0;
            org_z_reg <= '0;
            cpu_x_reg <= 32'd65536;
            cpu_z_reg <= 32'd65536;
            gres_reg  <= 8'd128;
            inv_reg   <= 32'd65536;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ORIGIN_X: org_x_reg <= cfg_wdata;
                CFG_ORIGIN_Z: org_z_reg <= cfg_wdata;
                CFG_CPU_X:    cpu_x_reg <= cfg_wdata;
                CFG_CPU_Z:    cpu_z_reg <= cfg_wdata;
                CFG_GRID_RES: gres_reg  <= cfg_wdata[7:0];
                CFG_INV_AREA: inv_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign res_w = ({24'd0, gres_reg} > 32'(MAX_RES)) ? RES_W'(MAX_RES) : RES_W'(gres_reg);

    // capture: offset from origin as sign and magnitude
    logic [32:0] dx_w, dz_w, mx_w, mz_w;
    logic [31:0] magx_reg, magz_reg;
    logic        negx_reg, negz_reg;
    logic [15:0] fr_reg, fg_reg, fb_reg;

    always_comb begin
        dx_w = {s_tdata[31], s_tdata[31:0]} - {org_x_reg[31], org_x_reg};
        dz_w = {s_tdata[63], s_tdata[63:32]} - {org_z_reg[31], org_z_reg};
        mx_w = dx_w[32] ? -dx_w : dx_w;
        mz_w = dz_w[32] ? -dz_w : dz_w;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            magx_reg <= mx_w[31:0];
            magz_reg <= mz_w[31:0];
            negx_reg <= dx_w[32];
            negz_reg <= dz_w[32];
            fr_reg   <= s_tdata[79:64];
            fg_reg   <= s_tdata[95:80];
            fb_reg   <= s_tdata[111:96];
        end
    end

    // map: scaled offsets
    logic [63:0] prodx_reg, prodz_reg;
    always_ff @(posedge aclk) begin
        if (cmd.map_en) begin
            prodx_reg <= 64'(magx_reg) * 64'(cpu_x_reg);
            prodz_reg <= 64'(magz_reg) * 64'(cpu_z_reg);
        end
    end

    // addr: range check and cell index
    logic [31:0]      cx_w, cz_w;
    logic             okx_w, okz_w;
    logic             ok_reg;
    logic [IDX_W-1:0] idx_reg;

    always_comb begin
        cx_w  = prodx_reg[63:32];
        cz_w  = prodz_reg[63:32];
        // a negative offset floors below cell 0 unless the scale is zero
        okx_w = !(negx_reg && (cpu_x_reg != '0)) && (cx_w < 32'(res_w));
        okz_w = !(negz_reg && (cpu_z_reg != '0)) && (cz_w < 32'(res_w));
    end

    always_ff @(posedge aclk) begin
        if (cmd.addr_en) begin
            ok_reg  <= okx_w && okz_w;
            idx_reg <= IDX_W'(cz_w[CRD_W-1:0]) * IDX_W'(res_w) + IDX_W'(cx_w[CRD_W-1:0]);
        end
    end

    // cell store {blue, green, red}
    logic [95:0] mem [CELLS];
    logic [95:0] rd_reg;
    logic [31:0] sr_w, sg_w, sb_w;

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_reg <= mem[idx_reg];
        end
        if (cmd.clr_we) begin
            mem[clr_addr] <= '0;
        end else if (cmd.add_en && ok_reg) begin
            mem[idx_reg] <= {sb_w, sg_w, sr_w};
        end
    end

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + 33'(b);
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [SUM_W-1:0] tot_add(input logic [SUM_W-1:0] t,
                                                  input logic [31:0] d);
        logic [SUM_W:0] s;
        s = {1'b0, t} + (SUM_W+1)'(d);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    assign sr_w = sat_add(rd_reg[31:0],  fr_reg);
    assign sg_w = sat_add(rd_reg[63:32], fg_reg);
    assign sb_w = sat_add(rd_reg[95:64], fb_reg);

    logic [SUM_W-1:0] tot_r_reg, tot_g_reg, tot_b_reg;
    logic [31:0]      peak_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [31:0]      cr_reg, cg_reg, cb_reg;
    logic             was_zero_w, now_zero_w;
    logic [31:0]      lum_w;
    logic [49:0]      wsum_w;
    logic [47:0]      lp_r_reg, lp_g_reg, lp_b_reg;

    assign was_zero_w = (rd_reg == '0);
    assign now_zero_w = ({sb_w, sg_w, sr_w} == '0);
    assign wsum_w     = 50'(lp_r_reg) + 50'(lp_g_reg) + 50'(lp_b_reg);
    assign lum_w      = 32'((wsum_w + 50'd32768) >> 16);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tot_r_reg <= '0;
            tot_g_reg <= '0;
            tot_b_reg <= '0;
            peak_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            if (cmd.add_en && ok_reg) begin
                tot_r_reg <= tot_add(tot_r_reg, sr_w - rd_reg[31:0]);
                tot_g_reg <= tot_add(tot_g_reg, sg_w - rd_reg[63:32]);
                tot_b_reg <= tot_add(tot_b_reg, sb_w - rd_reg[95:64]);
                if (was_zero_w && !now_zero_w) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (cmd.lum2_en && ok_reg && (lum_w > peak_reg)) begin
                peak_reg <= lum_w;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.add_en) begin
            cr_reg <= ok_reg ? sr_w : '0;
            cg_reg <= ok_reg ? sg_w : '0;
            cb_reg <= ok_reg ? sb_w : '0;
        end
    end

    // lum1: weighted products, irradiance products, total partials
    logic [63:0] ip_r_reg, ip_g_reg, ip_b_reg;
    logic [38:0] wl_r_reg, wl_g_reg, wl_b_reg, wh_r_reg, wh_g_reg, wh_b_reg;
    logic [WT_W-1:0] wtot_reg;

    always_ff @(posedge aclk) begin
        if (cmd.lum1_en) begin
            lp_r_reg <= 48'(cr_reg) * 48'(W_R);
            lp_g_reg <= 48'(cg_reg) * 48'(W_G);
            lp_b_reg <= 48'(cb_reg) * 48'(W_B);
            ip_r_reg <= 64'(cr_reg) * 64'(inv_reg);
            ip_g_reg <= 64'(cg_reg) * 64'(inv_reg);
            ip_b_reg <= 64'(cb_reg) * 64'(inv_reg);
            wl_r_reg <= 39'(tot_r_reg[22:0]) * 39'(W_R);
            wl_g_reg <= 39'(tot_g_reg[22:0]) * 39'(W_G);
            wl_b_reg <= 39'(tot_b_reg[22:0]) * 39'(W_B);
            wh_r_reg <= 39'(tot_r_reg[45:23]) * 39'(W_R);
            wh_g_reg <= 39'(tot_g_reg[45:23]) * 39'(W_G);
            wh_b_reg <= 39'(tot_b_reg[45:23]) * 39'(W_B);
        end
        if (cmd.lum2_en) begin
            wtot_reg <= WT_W'(wl_r_reg) + WT_W'(wl_g_reg) + WT_W'(wl_b_reg)
                      + ((WT_W'(wh_r_reg) + WT_W'(wh_g_reg) + WT_W'(wh_b_reg)) << 23);
        end
    end

    // mean: weighted total over nonzero count
    logic [WT_W-1:0] quot_w;
    logic [46:0]     qr_w;
    logic [31:0]     mq_reg;

    fga_div #(
        .DVD_W (WT_W),
        .DVS_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (wtot_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quot     (quot_w)
    );

    assign qr_w = 47'((63'(quot_w) + 63'd32768) >> 16);

    logic [63:0] pp_reg, mp_reg;
    always_ff @(posedge aclk) begin
        if (cmd.qrnd_en) begin
            mq_reg <= (|qr_w[46:32]) ? 32'hFFFF_FFFF : qr_w[31:0];
        end
        if (cmd.scale_en) begin
            pp_reg <= 64'(peak_reg) * 64'(inv_reg);
            mp_reg <= 64'(mq_reg) * 64'(inv_reg);
        end
    end

    // output register
    logic [OUT_DATA_W-1:0] otd_reg;
    logic                  otu_reg;
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            otu_reg <= ok_reg;
            otd_reg <= {(OUT_DATA_W-O_END)'(0),
                        ((cnt_reg == '0) ? 32'd0 : sat_scale(mp_reg)),
                        15'(cnt_reg),
                        sat_scale(pp_reg),
                        tot_b_reg,
                        tot_g_reg,
                        tot_r_reg,
                        sat_scale(ip_b_reg),
                        sat_scale(ip_g_reg),
                        sat_scale(ip_r_reg)};
        end
    end

    assign m_tdata = otd_reg;
    assign m_tuser = otu_reg;

endmodule

// ----- rtl/flux_grid_accumulator.sv -----
// ----------------------------------------------------------------------------
// flux_grid_accumulator
// Bins Q16.16 ground-plane hits into a square grid and accumulates Q8.8 RGB
// flux per cell, reporting cell irradiance, totals, peak and mean.
// ----------------------------------------------------------------------------
// After reset the cell store is swept to zero, one cell per cycle, and
// s_axis_tready stays low until the sweep is done; config writes are taken
// throughout. Each input transaction then goes from acceptance to its result
// being presented through ten sequencer steps (bin, index, cell read,
// saturating add and write-back, luminance, peak, divider start, rounding,
// scaling, output load), with a wait between divider start and rounding on
// the bit-serial mean divider of the 62-bit weighted total until its done
// flag. One transaction is worked on at a time; the next is accepted the
// cycle after the result is loaded into the output register, even if it has
// not been taken yet. A result still held in the output register when the
// next one is ready stalls it. Zero flux is a query: it leaves the store
// unchanged. Config registers must only be written while no transaction is
// in flight.
// ----------------------------------------------------------------------------
module flux_grid_accumulator import fga_pkg::*; #(
    parameter int MAX_RES = MAX_RES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // config write port: index 0 origin_x, 1 origin_z, 2 cells_per_unit_x,
    // 3 cells_per_unit_z, 4 grid_resolution, 5 inverse_cell_area
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pos_x[31:0], pos_z[63:32], flux_r[79:64], flux_g[95:80], flux_b[111:96]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // irr_r[31:0], irr_g[63:32], irr_b[95:64], sum_r[141:96], sum_g[187:142],
    // sum_b[233:188], peak_irr[265:234], nonzero_cells[280:266],
    // mean_irr[312:281], zero fill [319:313]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // in_range[0]
    output logic                  m_axis_tuser
);
    localparam int CELLS = MAX_RES * MAX_RES;
    localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    fga_cmd_t         cmd;
    logic             div_done;
    logic [IDX_W-1:0] clr_addr;

    // sequencer
    fga_ctrl #(
        .MAX_RES (MAX_RES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .div_done (div_done),
        .cmd      (cmd),
        .clr_addr (clr_addr)
    );

    // arithmetic, cell store and output register
    fga_datapath #(
        .MAX_RES (MAX_RES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .clr_addr  (clr_addr),
        .div_done  (div_done),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_axis_tdata),
        .m_tdata   (m_axis_tdata),
        .m_tuser   (m_axis_tuser)
    );

    // one transaction in flight: no back-to-back acceptance
    a_single_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second transaction accepted while one is in flight");

    // an out-of-grid result reports zero cell irradiance
    a_out_of_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[O_SUM_R-1:O_IRR_R] == '0))
        else $error("out-of-grid result carries cell irradiance");

    // no input accepted while the store is being cleared
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_we |-> !s_axis_tready)
        else $error("input accepted during clear sweep");

endmodule
